// File: src/u2u8_pkg.sv
// Shared types, constants and the UTF-8 byte builder for the UTF-16 to UTF-8 encoder.
// No dependencies; every other file in src imports this package.
package u2u8_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CAP_WIDTH       = 16;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 16'd1024;
    localparam int QUEUE_DEPTH     = 2;

    // End-of-conversion status carried on the final result of an item
    typedef enum logic [1:0] {
        ST_RUNNING   = 2'd0,
        ST_DONE      = 2'd1,
        ST_NO_ROOM   = 2'd2,
        ST_EXHAUSTED = 2'd3
    } status_t;

    // One item's work, as the front hands it to the back.
    // seg0: pair or lone high surrogate (up to 4 bytes),
    // seg1: current unit or terminator (up to 3 bytes),
    // tail: a status-only result after the bytes.
    typedef struct packed {
        logic        clear;    // reset running counters before this job
        logic [20:0] cp0;
        logic [2:0]  len0;
        logic [1:0]  units0;
        logic [15:0] cp1;
        logic [1:0]  len1;
        logic        units1;
        logic        tail;
        status_t     status;
        logic [2:0]  need;
    } job_t;

    // Build byte number pos of the UTF-8 form of cp, which is len bytes long
    function automatic logic [7:0] enc_byte(logic [20:0] cp, logic [2:0] len,
                                            logic [1:0] pos);
        logic [7:0] b;
        b = 8'h00;
        case (len)
            3'd1: b = cp[7:0];
            3'd2: b = (pos == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3: begin
                case (pos)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            3'd4: begin
                case (pos)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: src/u2u8_front.sv
// Front end: accepts code units, pairs surrogates, checks room and plans each item's results.
// Depends on u2u8_pkg; feeds jobs into u2u8_queue.
module u2u8_front
    import u2u8_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CAP_WIDTH-1:0] cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [15:0]          s_code_unit,
    input  logic                 s_last_unit,
    input  logic                 s_new_string,
    input  logic                 q_full,
    output logic                 q_push,
    output job_t                 q_job
);

    localparam int DW = ((COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH) + 1;

    logic [CAP_WIDTH-1:0]   cap_reg;
    logic [15:0]            held_high_reg, held_high_next;
    logic                   held_valid_reg, held_valid_next;
    logic                   fin_reg, fin_next;
    logic                   pend_reg, pend_next;
    logic [COUNT_WIDTH-1:0] wc_reg, wc_next;

    logic                   accept;
    logic                   held_v, fin;
    logic [COUNT_WIDTH-1:0] wc;
    logic signed [DW-1:0]   diff;
    logic                   is_high, is_low, is_zero;
    logic [1:0]             cu_len;
    logic [2:0]             cur_need;
    logic [2:0]             base_len;
    logic                   fit_pair, fit_hi, fit_cur;
    logic                   push;
    job_t                   job;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && !q_full;

    // Start of a new string wipes the conversion state before the unit is handled
    assign held_v = !s_new_string && held_valid_reg;
    assign fin    = !s_new_string && fin_reg;
    assign wc     = s_new_string ? '0 : wc_reg;

    // Free room, signed so that capacity below the count reads as no room
    assign diff = $signed(DW'(cap_reg)) - $signed(DW'(wc));

    assign is_high = (s_code_unit[15:10] == 6'b110110);
    assign is_low  = (s_code_unit[15:10] == 6'b110111);
    assign is_zero = (s_code_unit == 16'h0000);
    assign cu_len  = (s_code_unit < 16'h0080) ? 2'd1 :
                     (s_code_unit < 16'h0800) ? 2'd2 : 2'd3;

    assign base_len = held_v ? 3'd3 : 3'd0;
    assign cur_need = is_zero ? 3'd1 : {1'b0, cu_len};
    assign fit_pair = diff >= $signed(DW'(4));
    assign fit_hi   = diff >= $signed(DW'(3));
    assign fit_cur  = diff >= $signed(DW'(base_len + cur_need));

    // Plan the item
    always_comb begin
        job             = '0;
        job.status      = ST_RUNNING;
        job.clear       = s_new_string || pend_reg;
        push            = 1'b0;
        held_valid_next = held_v;
        held_high_next  = held_high_reg;
        fin_next        = fin;

        if (!fin) begin
            held_valid_next = 1'b0;
            if (held_v && is_low) begin
                // Surrogate pair: one four-byte code point
                job.cp0    = 21'h10000 + {1'b0, held_high_reg[9:0], s_code_unit[9:0]};
                job.units0 = 2'd2;
                push       = 1'b1;
                if (fit_pair) begin
                    job.len0 = 3'd4;
                    if (s_last_unit) begin
                        job.status = ST_EXHAUSTED;
                        fin_next   = 1'b1;
                    end
                end else begin
                    job.tail   = 1'b1;
                    job.status = ST_NO_ROOM;
                    job.need   = 3'd4;
                    fin_next   = 1'b1;
                end
            end else if (held_v && !fit_hi) begin
                // Lone high does not fit: stop here
                job.tail   = 1'b1;
                job.status = ST_NO_ROOM;
                job.need   = 3'd3;
                fin_next   = 1'b1;
                push       = 1'b1;
            end else begin
                if (held_v) begin
                    job.cp0    = {5'd0, held_high_reg};
                    job.len0   = 3'd3;
                    job.units0 = 2'd1;
                    push       = 1'b1;
                end
                if (is_high) begin
                    if (s_last_unit) begin
                        job.status = ST_EXHAUSTED;
                        job.tail   = !held_v;
                        fin_next   = 1'b1;
                        push       = 1'b1;
                    end else begin
                        held_valid_next = 1'b1;
                        held_high_next  = s_code_unit;
                    end
                end else if (is_zero) begin
                    fin_next = 1'b1;
                    push     = 1'b1;
                    if (fit_cur) begin
                        job.len1   = 2'd1;
                        job.status = ST_DONE;
                    end else begin
                        job.tail   = 1'b1;
                        job.status = ST_NO_ROOM;
                        job.need   = 3'd1;
                    end
                end else begin
                    push = 1'b1;
                    if (fit_cur) begin
                        job.cp1    = s_code_unit;
                        job.len1   = cu_len;
                        job.units1 = 1'b1;
                        if (s_last_unit) begin
                            job.status = ST_EXHAUSTED;
                            fin_next   = 1'b1;
                        end
                    end else begin
                        job.tail   = 1'b1;
                        job.status = ST_NO_ROOM;
                        job.need   = {1'b0, cu_len};
                        fin_next   = 1'b1;
                    end
                end
            end
        end

        wc_next   = wc + COUNT_WIDTH'(job.len0) + COUNT_WIDTH'(job.len1);
        pend_next = push ? 1'b0 : job.clear;
    end

    assign q_push = accept && push;
    assign q_job  = job;

    // Hold conversion state and the capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg        <= CAP_RESET;
            held_valid_reg <= 1'b0;
            fin_reg        <= 1'b0;
            pend_reg       <= 1'b0;
            wc_reg         <= '0;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (accept) begin
                held_valid_reg <= held_valid_next;
                fin_reg        <= fin_next;
                pend_reg       <= pend_next;
                wc_reg         <= wc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held_high_reg <= held_high_next;
        end
    end

endmodule

// File: src/u2u8_queue.sv
// Short job queue between the front and the back end.
// Depends on u2u8_pkg for job_t and the depth.
module u2u8_queue
    import u2u8_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head,
    output logic head_valid
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    job_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and the fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: src/u2u8_back.sv
// Back end: walks each job one result per cycle, when m_ready does not stall it, into a registered output beat.
// Depends on u2u8_pkg; takes jobs from u2u8_queue.
module u2u8_back
    import u2u8_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  job_t        q_head,
    input  logic        q_head_valid,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic [1:0]  m_status,
    output logic [2:0]  m_needed_length,
    output logic [15:0] m_bytes_total,
    output logic [15:0] m_units_consumed,
    output logic        m_last_result
);

    job_t                   cur_reg;
    logic                   cur_valid_reg;
    logic [2:0]             k_reg;
    logic [COUNT_WIDTH-1:0] wc_reg, wc_next;
    logic [COUNT_WIDTH-1:0] cc_reg, cc_next;
    logic [COUNT_WIDTH-1:0] wc_inc, cc_inc;

    logic                   m_valid_reg;
    logic [7:0]             byte_reg;
    logic                   byte_valid_reg;
    status_t                status_reg;
    logic [2:0]             need_reg;
    logic [15:0]            bytes_total_reg, units_reg;
    logic                   last_reg;

    logic [2:0]             l0, l01, total;
    logic                   in0, in1, is_tail, seg_end, is_last;
    logic [1:0]             pos, units;
    logic [7:0]             byte_val;
    logic                   fire, load;

    // Locate the current result inside the job
    assign l0      = cur_reg.len0;
    assign l01     = cur_reg.len0 + {1'b0, cur_reg.len1};
    assign total   = l01 + {2'b00, cur_reg.tail};
    assign in0     = k_reg < l0;
    assign in1     = !in0 && (k_reg < l01);
    assign is_tail = !in0 && !in1;
    assign pos     = in0 ? k_reg[1:0] : 2'(k_reg - l0);
    assign seg_end = (in0 && (k_reg == l0 - 3'd1)) || (in1 && (k_reg == l01 - 3'd1));
    assign units   = in0 ? cur_reg.units0 : {1'b0, cur_reg.units1};
    assign is_last = (k_reg == total - 3'd1);

    assign byte_val = in0 ? enc_byte(cur_reg.cp0, cur_reg.len0, pos) :
                      in1 ? enc_byte({5'd0, cur_reg.cp1}, {1'b0, cur_reg.len1}, pos) :
                            8'h00;

    assign fire  = cur_valid_reg && (!m_valid_reg || m_ready);
    assign load  = !cur_valid_reg || (fire && is_last);
    assign q_pop = load && q_head_valid;

    // Counter increments, wrapped at the counter width
    assign wc_inc = wc_reg + 1'b1;
    assign cc_inc = cc_reg + COUNT_WIDTH'(units);

    // Running counters; a clearing job zeroes them as it is loaded
    always_comb begin
        wc_next = wc_reg;
        cc_next = cc_reg;
        if (fire && !is_tail) begin
            wc_next = wc_inc;
            if (seg_end) begin
                cc_next = cc_inc;
            end
        end
        if (q_pop && q_head.clear) begin
            wc_next = '0;
            cc_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            k_reg         <= '0;
            wc_reg        <= '0;
            cc_reg        <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            wc_reg <= wc_next;
            cc_reg <= cc_next;
            // Advance within the job or take the next one
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                k_reg         <= '0;
            end else if (fire && is_last) begin
                cur_valid_reg <= 1'b0;
            end else if (fire) begin
                k_reg <= k_reg + 1'b1;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Job register and output beat payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_head;
        end
        if (fire) begin
            byte_reg        <= byte_val;
            byte_valid_reg  <= !is_tail;
            status_reg      <= is_last ? cur_reg.status : ST_RUNNING;
            need_reg        <= is_tail ? cur_reg.need : 3'd0;
            bytes_total_reg <= 16'(is_tail ? wc_reg : wc_inc);
            units_reg       <= 16'((!is_tail && seg_end) ? cc_inc : cc_reg);
            last_reg        <= is_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_byte       = byte_reg;
    assign m_byte_valid     = byte_valid_reg;
    assign m_status         = status_reg;
    assign m_needed_length  = need_reg;
    assign m_bytes_total    = bytes_total_reg;
    assign m_units_consumed = units_reg;
    assign m_last_result    = last_reg;

endmodule

// File: src/utf16_to_utf8_bounded_encoder.sv
// UTF-16 to UTF-8 bounded encoder: front end, two-entry job queue, back end.
// Throughput: one result beat per cycle while m_ready does not stall the output, up to 6 results per unit,
// set by the single byte-wide output register of the back end.
// Reset (aresetn low, synchronous): capacity 1024, counters, held surrogate and queue cleared.
// Depends on u2u8_pkg, u2u8_front, u2u8_queue and u2u8_back.
module utf16_to_utf8_bounded_encoder
    import u2u8_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CAP_WIDTH-1:0] cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [15:0]          s_code_unit,
    input  logic                 s_last_unit,
    input  logic                 s_new_string,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_byte,
    output logic                 m_byte_valid,
    output logic [1:0]           m_status,
    output logic [2:0]           m_needed_length,
    output logic [15:0]          m_bytes_total,
    output logic [15:0]          m_units_consumed,
    output logic                 m_last_result
);

    logic q_full, q_push, q_pop, q_head_valid;
    job_t q_job, q_head;

    u2u8_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_code_unit  (s_code_unit),
        .s_last_unit  (s_last_unit),
        .s_new_string (s_new_string),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_job)
    );

    u2u8_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid)
    );

    u2u8_back #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_head           (q_head),
        .q_head_valid     (q_head_valid),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_byte_valid     (m_byte_valid),
        .m_status         (m_status),
        .m_needed_length  (m_needed_length),
        .m_bytes_total    (m_bytes_total),
        .m_units_consumed (m_units_consumed),
        .m_last_result    (m_last_result)
    );

endmodule

// File: src/u2u8_checker.sv
// Port-level checks on the encoder's result channel, bound to the top level.
// Depends on u2u8_pkg for status codes.
module u2u8_checker
    import u2u8_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_byte_valid,
    input logic [1:0]  m_status,
    input logic [2:0]  m_needed_length,
    input logic        m_last_result
);

    // Stalled beat holds its byte
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte))
        else $error("result beat changed while stalled");

    // Only the final result of an item ends the conversion
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_RUNNING) |-> m_last_result)
        else $error("status on a non-final result");

    // Status-only results carry a zero byte
    a_empty_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> (m_out_byte == 8'h00) && m_last_result)
        else $error("status-only result with a byte");

    // Needed length appears only on a no-room status result
    a_need: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_needed_length != 3'd0) |->
            (m_status == ST_NO_ROOM) && !m_byte_valid)
        else $error("needed length outside a no-room result");

endmodule

bind utf16_to_utf8_bounded_encoder u2u8_checker u_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_out_byte      (m_out_byte),
    .m_byte_valid    (m_byte_valid),
    .m_status        (m_status),
    .m_needed_length (m_needed_length),
    .m_last_result   (m_last_result)
);
